// File: rtl/pbk_pkg.sv
// Shared types and codes for the price level book.
package pbk_pkg;

  // Request fields of one market event
  typedef struct packed {
    logic        is_add;
    logic        side;
    logic [31:0] price;
    logic [31:0] quantity;
  } pbk_in_t;

  // Result fields reported after every event
  typedef struct packed {
    logic [31:0] best_bid_price;
    logic [31:0] best_bid_qty;
    logic [31:0] best_ask_price;
    logic [31:0] best_ask_qty;
    logic [1:0]  status;
  } pbk_out_t;

  // One stored level
  typedef struct packed {
    logic [31:0] price;
    logic [31:0] qty;
  } pbk_level_t;

  localparam int LevelW = $bits(pbk_level_t);

  // Status codes
  typedef enum logic [1:0] {
    ST_MERGED  = 2'd0,
    ST_NEW     = 2'd1,
    ST_FULL    = 2'd2,
    ST_IGNORED = 2'd3
  } pbk_status_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic        load_in;
    logic        rd_en;
    logic        idx_inc;
    logic        wr_merge;
    logic        wr_new;
    logic        set_status;
    pbk_status_t status;
    logic        load_out;
  } pbk_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic is_add;
    logic side_empty;
    logic match;
    logic last_idx;
    logic side_full;
    logic out_free;
  } pbk_stat_t;

endpackage

// File: rtl/price_level_book.sv
// An ignored event or an add to an empty side goes from dispatch straight to done; else the
// scan reads the side's levels in turn (up to the side's level count) until a match or the last.
// One event is handled at a time: a new request is taken only once the last result is loaded
// into the output register; the scan reads levels through the single read port of the level memory.
// Reset (rst_n low, synchronous) empties both sides; level memory is not cleared.
// A finished result waits in an output register while the next request is taken.
module price_level_book #(
  parameter int LEVELS = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  pbk_pkg::pbk_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output pbk_pkg::pbk_out_t out_data
);
  import pbk_pkg::*;

  pbk_cmd_t  cmd;
  pbk_stat_t stat;

  pbk_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  pbk_dpath #(
    .LEVELS (LEVELS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// File: rtl/pbk_ram.sv
// Generic single write port, single read port RAM with registered read.
module pbk_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/pbk_ctrl.sv
// Controller state machine: sequences the level scan and the result hand-off.
module pbk_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  pbk_pkg::pbk_stat_t stat,
  output pbk_pkg::pbk_cmd_t  cmd
);
  import pbk_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISP,
    S_RD,
    S_CMP,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;

  // Decode commands and next state
  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    cmd.status = ST_IGNORED;
    in_ready   = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_DISP;
        end
      end
      S_DISP: begin
        if (!stat.is_add) begin
          cmd.set_status = 1'b1;
          cmd.status     = ST_IGNORED;
          state_nxt      = S_DONE;
        end else if (stat.side_empty) begin
          cmd.wr_new     = 1'b1;
          cmd.set_status = 1'b1;
          cmd.status     = ST_NEW;
          state_nxt      = S_DONE;
        end else begin
          cmd.rd_en = 1'b1;
          state_nxt = S_CMP;
        end
      end
      S_RD: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        priority if (stat.match) begin
          cmd.wr_merge   = 1'b1;
          cmd.set_status = 1'b1;
          cmd.status     = ST_MERGED;
          state_nxt      = S_DONE;
        end else if (stat.last_idx && stat.side_full) begin
          cmd.set_status = 1'b1;
          cmd.status     = ST_FULL;
          state_nxt      = S_DONE;
        end else if (stat.last_idx) begin
          cmd.wr_new     = 1'b1;
          cmd.set_status = 1'b1;
          cmd.status     = ST_NEW;
          state_nxt      = S_DONE;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = S_RD;
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: rtl/pbk_dpath.sv
// Datapath: event register, level memory, counts, best levels, result register.
module pbk_dpath #(
  parameter int LEVELS = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  pbk_pkg::pbk_in_t   in_data,
  input  pbk_pkg::pbk_cmd_t  cmd,
  output pbk_pkg::pbk_stat_t stat,
  output logic               out_valid,
  input  logic               out_ready,
  output pbk_pkg::pbk_out_t  out_data
);
  import pbk_pkg::*;

  localparam int IdxW  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int CntW  = $clog2(LEVELS + 1);
  localparam int Depth = 2 << IdxW;
  localparam int AddrW = IdxW + 1;

  pbk_in_t          ev_r;
  logic [IdxW-1:0]  idx_r;
  logic [CntW-1:0]  buy_cnt_r, sell_cnt_r;
  logic [31:0]      bid_p_r, bid_q_r, ask_p_r, ask_q_r;
  pbk_status_t      status_r;
  logic             out_valid_r;
  pbk_out_t         out_r;

  logic [CntW-1:0]  side_cnt;
  pbk_level_t       rd_lvl;
  pbk_level_t       wr_lvl;
  logic [AddrW-1:0] wr_addr;
  logic             wr_en;
  logic [32:0]      sum;
  logic [31:0]      sat_q;
  logic [CntW:0]    next_idx;

  assign side_cnt = ev_r.side ? sell_cnt_r : buy_cnt_r;
  assign sum      = {1'b0, rd_lvl.qty} + {1'b0, ev_r.quantity};
  assign sat_q    = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
  assign next_idx = (CntW + 1)'(idx_r) + (CntW + 1)'(1);

  // Status toward the controller
  assign stat.is_add     = ev_r.is_add;
  assign stat.side_empty = (side_cnt == '0);
  assign stat.match      = (rd_lvl.price == ev_r.price);
  assign stat.last_idx   = (next_idx >= {1'b0, side_cnt});
  assign stat.side_full  = (side_cnt == CntW'(LEVELS));
  assign stat.out_free   = !out_valid_r || out_ready;

  // Select write address and data: merge in place or append
  assign wr_en       = cmd.wr_merge || cmd.wr_new;
  assign wr_lvl.price = ev_r.price;
  assign wr_lvl.qty   = cmd.wr_merge ? sat_q : ev_r.quantity;
  assign wr_addr      = cmd.wr_merge ? {ev_r.side, idx_r}
                                     : {ev_r.side, side_cnt[IdxW-1:0]};

  pbk_ram #(
    .WIDTH (LevelW),
    .DEPTH (Depth)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_lvl),
    .rd_en   (cmd.rd_en),
    .rd_addr ({ev_r.side, idx_r}),
    .rd_data (rd_lvl)
  );

  // Capture request, advance scan index, hold status code
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      ev_r  <= in_data;
      idx_r <= '0;
    end else if (cmd.idx_inc) begin
      idx_r <= idx_r + IdxW'(1);
    end
    if (cmd.set_status) begin
      status_r <= cmd.status;
    end
  end

  // Level counts
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buy_cnt_r  <= '0;
      sell_cnt_r <= '0;
    end else if (cmd.wr_new) begin
      if (ev_r.side) begin
        sell_cnt_r <= sell_cnt_r + CntW'(1);
      end else begin
        buy_cnt_r <= buy_cnt_r + CntW'(1);
      end
    end
  end

  // Track best levels; prices on a side are unique, so a merge hits best only by price
  always_ff @(posedge clk) begin
    if (cmd.wr_new) begin
      if (!ev_r.side && (buy_cnt_r == '0 || ev_r.price > bid_p_r)) begin
        bid_p_r <= ev_r.price;
        bid_q_r <= ev_r.quantity;
      end
      if (ev_r.side && (sell_cnt_r == '0 || ev_r.price < ask_p_r)) begin
        ask_p_r <= ev_r.price;
        ask_q_r <= ev_r.quantity;
      end
    end else if (cmd.wr_merge) begin
      if (!ev_r.side && ev_r.price == bid_p_r) begin
        bid_q_r <= sat_q;
      end
      if (ev_r.side && ev_r.price == ask_p_r) begin
        ask_q_r <= sat_q;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_r.best_bid_price <= (buy_cnt_r == '0) ? 32'd0 : bid_p_r;
      out_r.best_bid_qty   <= (buy_cnt_r == '0) ? 32'd0 : bid_q_r;
      out_r.best_ask_price <= (sell_cnt_r == '0) ? 32'd0 : ask_p_r;
      out_r.best_ask_qty   <= (sell_cnt_r == '0) ? 32'd0 : ask_q_r;
      out_r.status         <= status_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (buy_cnt_r <= CntW'(LEVELS)) && (sell_cnt_r <= CntW'(LEVELS)))
    else $error("level count beyond table depth");
  a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.wr_merge && cmd.wr_new))
    else $error("merge and append in one cycle");
  a_no_append_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_new |-> !stat.side_full)
    else $error("append on a full side");
  a_load_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> out_valid_r)
    else $error("result not presented after load");
`endif

endmodule
